// ----- sv/ptd_pkg.sv -----
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

    localparam int DIV_W = 32;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- sv/ptd_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ptd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptd_pkg::t_div_req i_req,
    output ptd_pkg::t_div_rsp o_rsp
);

    localparam int W     = ptd_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     n_quo;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (!w_diff[W]) begin
            n_rem = w_diff[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- sv/periodic_task_dispatcher_top.sv -----
// Periodic task dispatcher: task slot table, tick scan sequencer and shared divider.
// Stop, start, unknown ops and early rejects go straight to the result; register and set
// period that pass the early checks first run the 32-step modulo on the divider.
// Tick: per enabled slot (none if tick is zero) divide period by tick, then tick count by
// a nonzero quotient; input reopens as the result registers, later while output stalls.
// Reset (synchronous, active low) clears counts, enables, sequencer, output; tick 1, base 60000.
module periodic_task_dispatcher_top #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_period,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_fire_mask,
    output logic [3:0]  o_status,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_REG   = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_START = 3'd3;
    localparam logic [2:0] FN_SETP  = 3'd4;

    localparam logic [1:0] CFG_TICK_MS = 2'd0;
    localparam logic [1:0] CFG_BASE_MS = 2'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_DIVA = 6'b000100,
        S_DIVB = 6'b001000,
        S_CHK  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // latched item
    logic [2:0]  r_func;
    logic [7:0]  r_id;
    logic [31:0] r_period;

    // work registers
    logic [CW-1:0] r_slot, n_slot;
    logic [7:0]    r_mask, n_mask;
    logic [3:0]    r_status, n_status;

    // architectural state
    logic [31:0]           r_tick_cnt, n_tick_cnt;
    logic [CW-1:0]         r_count, n_count;
    logic [TASK_SLOTS-1:0] r_en, n_en;
    logic [31:0]           r_tab [TASK_SLOTS];
    logic [31:0]           r_tab_rd;
    logic [15:0]           r_tick_ms;
    logic [31:0]           r_base_ms;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_mask;
    logic [3:0] r_out_status;

    logic              w_accept;
    logic              w_tab_we;
    logic [SW-1:0]     w_tab_addr;
    logic              w_id_ok;
    logic              w_p_pre;
    logic [SW-1:0]     w_in_slot;
    logic [SW-1:0]     w_id_slot;
    logic [SW-1:0]     w_scan_slot;
    logic [31:0]       w_slot32;
    logic              w_out_free;

    ptd_pkg::t_div_req w_div_req;
    ptd_pkg::t_div_rsp w_div_rsp;

    ptd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // id range 1..TASK_SLOTS, period nonzero and not shorter than a tick
    assign w_id_ok     = (i_task_id != 8'd0) && (32'(i_task_id) <= 32'(TASK_SLOTS));
    assign w_p_pre     = (i_period != 32'd0) && (i_period >= {16'd0, r_tick_ms});
    assign w_in_slot   = SW'(i_task_id - 8'd1);
    assign w_id_slot   = SW'(r_id - 8'd1);
    assign w_scan_slot = r_slot[SW-1:0];
    assign w_slot32    = 32'(r_slot);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_mask      = r_mask;
        n_status    = r_status;
        n_tick_cnt  = r_tick_cnt;
        n_count     = r_count;
        n_en        = r_en;
        n_out_valid = r_out_valid;
        w_tab_we    = 1'b0;
        w_tab_addr  = r_count[SW-1:0];
        w_div_req   = '0;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mask   = 8'd0;
                    n_status = 4'd0;
                    n_state  = S_FIN;
                    case (i_func)
                        FN_TICK: begin
                            // advance the tick count before the scan
                            n_tick_cnt = r_tick_cnt + 32'd1;
                            n_slot     = '0;
                            n_status   = 4'd1;
                            n_state    = S_SCAN;
                        end
                        FN_REG: begin
                            if ((r_count < CW'(TASK_SLOTS)) && w_p_pre) begin
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = r_base_ms;
                                w_div_req.divisor  = i_period;
                                n_state            = S_CHK;
                            end
                        end
                        FN_STOP, FN_START: begin
                            if (w_id_ok) begin
                                n_en[w_in_slot] = (i_func == FN_START);
                                n_status        = 4'd1;
                            end
                        end
                        FN_SETP: begin
                            if (w_id_ok && w_p_pre) begin
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = r_base_ms;
                                w_div_req.divisor  = i_period;
                                n_state            = S_CHK;
                            end
                        end
                        default: begin
                            n_status = 4'd0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_slot < r_count) begin
                    if (r_en[w_scan_slot] && (r_tick_ms != 16'd0)) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = r_tab_rd;
                        w_div_req.divisor  = {16'd0, r_tick_ms};
                        n_state            = S_DIVA;
                    end else begin
                        n_slot = r_slot + CW'(1);
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIVA: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quotient == 32'd0) begin
                        n_slot  = r_slot + CW'(1);
                        n_state = S_SCAN;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = r_tick_cnt;
                        w_div_req.divisor  = w_div_rsp.quotient;
                        n_state            = S_DIVB;
                    end
                end
            end
            S_DIVB: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.remainder == 32'd0) begin
                        for (int k = 0; k < 8; k++) begin
                            if (w_slot32 == 32'(k)) begin
                                n_mask[k] = 1'b1;
                            end
                        end
                    end
                    n_slot  = r_slot + CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_CHK: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.remainder == 32'd0) begin
                        w_tab_we = 1'b1;
                        if (r_func == FN_REG) begin
                            w_tab_addr               = r_count[SW-1:0];
                            n_en[r_count[SW-1:0]]    = 1'b1;
                            n_count                  = r_count + CW'(1);
                            n_status                 = 4'(r_count + CW'(1));
                        end else begin
                            w_tab_addr      = w_id_slot;
                            n_en[w_id_slot] = 1'b1;
                            n_status        = 4'd1;
                        end
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_mask      <= 8'd0;
            r_status    <= 4'd0;
            r_tick_cnt  <= 32'd0;
            r_count     <= '0;
            r_en        <= '0;
            r_out_valid <= 1'b0;
            r_tick_ms   <= 16'd1;
            r_base_ms   <= 32'd60000;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_mask      <= n_mask;
            r_status    <= n_status;
            r_tick_cnt  <= n_tick_cnt;
            r_count     <= n_count;
            r_en        <= n_en;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TICK_MS: r_tick_ms <= i_cfg_data[15:0];
                    CFG_BASE_MS: r_base_ms <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers: item latch, period table and its scan read, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_id     <= i_task_id;
            r_period <= i_period;
        end
        if (w_tab_we) begin
            r_tab[w_tab_addr] <= r_period;
        end
        // fetch the period of the slot the scan looks at next
        r_tab_rd <= r_tab[n_slot[SW-1:0]];
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_mask   <= r_mask;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fire_mask = r_out_mask;
    assign o_status    = r_out_status;

endmodule

// ----- sv/ptd_chk.sv -----
// Port-level checker for the periodic task dispatcher, with its bind.
module ptd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_stall,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [7:0] i_fire_mask,
    input logic [3:0] i_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_fire_mask) && $stable(i_status))
        else $error("stalled result changed");

    // a result that fires tasks reports success, as a tick always does
    a_mask_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_fire_mask != 8'd0) |-> (i_status == 4'd1))
        else $error("fire mask on a non-tick result");

    // one item in work at a time: a transfer closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input open right after a transfer");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind periodic_task_dispatcher_top ptd_chk u_ptd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_fire_mask (o_fire_mask),
    .i_status    (o_status)
);

// ----- test/ptd_tb_pkg.sv -----
`timescale 1ns / 1ps
// Operation codes, register indexes and status codes shared by the dispatcher testbench.
package ptd_tb_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_REGISTER   = 3'd1,
        OP_STOP       = 3'd2,
        OP_START      = 3'd3,
        OP_SET_PERIOD = 3'd4,
        OP_RSVD5      = 3'd5,
        OP_RSVD6      = 3'd6,
        OP_RSVD7      = 3'd7
    } t_op;

    localparam logic [1:0] CFG_TICK_MS     = 2'd0;
    localparam logic [1:0] CFG_PERIOD_BASE = 2'd1;

    localparam logic [3:0] STATUS_FAIL = 4'd0;
    localparam logic [3:0] STATUS_OK   = 4'd1;

endpackage

// ----- test/ptd_checker.sv -----
`timescale 1ns / 1ps
// Checker for the periodic task dispatcher: tracks the slot table and compares every reply.
module ptd_checker #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_period,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_fire_mask,
    input  logic [3:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int unsigned o_replies_seen,
    output int unsigned o_fail_count
);

    typedef struct packed {
        logic [7:0] fire_mask;
        logic [3:0] status;
    } t_reply;

    t_reply      expected_replies[$];
    int unsigned n_outstanding = 0;
    int unsigned n_errors = 0;

    logic [15:0] tick_len;
    logic [31:0] base_len;
    int unsigned n_tasks;
    logic [31:0] tick_no;
    logic [31:0] slot_period [TASK_SLOTS];
    logic        slot_on     [TASK_SLOTS];

    assign o_fail_count = n_errors + n_outstanding;

    function automatic logic period_fits(input logic [31:0] p);
        return p != 0 && p >= {16'd0, tick_len} && (base_len % p) == 0;
    endfunction

    // Apply one operation to the tracked table and return the reply it gives.
    task automatic dispatch_op(input ptd_tb_pkg::t_op op, input logic [7:0] id,
                               input logic [31:0] p, output t_reply r);
        logic [31:0] div;
        int          i;
        r = '0;
        case (op)
            ptd_tb_pkg::OP_TICK: begin
                tick_no = tick_no + 1;
                for (i = 0; i < n_tasks && i < TASK_SLOTS && i < 8; i++) begin
                    div = (tick_len == 0) ? 32'd0 : slot_period[i] / {16'd0, tick_len};
                    if (div != 0 && slot_on[i] && (tick_no % div) == 0)
                        r.fire_mask[i] = 1'b1;
                end
                r.status = ptd_tb_pkg::STATUS_OK;
            end
            ptd_tb_pkg::OP_REGISTER: begin
                if (n_tasks < TASK_SLOTS && period_fits(p)) begin
                    slot_period[n_tasks] = p;
                    slot_on[n_tasks] = 1'b1;
                    n_tasks++;
                    r.status = 4'(n_tasks);
                end
            end
            ptd_tb_pkg::OP_STOP, ptd_tb_pkg::OP_START: begin
                if (id >= 1 && id <= TASK_SLOTS) begin
                    slot_on[id - 1] = (op == ptd_tb_pkg::OP_START);
                    r.status = ptd_tb_pkg::STATUS_OK;
                end
            end
            ptd_tb_pkg::OP_SET_PERIOD: begin
                if (id >= 1 && id <= TASK_SLOTS && period_fits(p)) begin
                    slot_period[id - 1] = p;
                    slot_on[id - 1] = 1'b1;
                    r.status = ptd_tb_pkg::STATUS_OK;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_reply want;
        t_reply fresh;
        int     i;
        if (!i_rst_n) begin
            tick_len = 16'd1;
            base_len = 32'd60000;
            n_tasks = 0;
            tick_no = '0;
            for (i = 0; i < TASK_SLOTS; i++) begin
                slot_period[i] = '0;
                slot_on[i] = 1'b0;
            end
            expected_replies.delete();
            n_outstanding = 0;
            o_replies_seen <= 0;
        end else begin
            // Retire the oldest expectation against the reply transfer.
            if (i_out_valid && !i_out_stall) begin
                o_replies_seen <= o_replies_seen + 1;
                if (n_outstanding == 0) begin
                    note_error("unexpected reply", '0, {20'd0, i_fire_mask, i_status});
                end else begin
                    want = expected_replies.pop_front();
                    n_outstanding--;
                    if (i_fire_mask !== want.fire_mask)
                        note_error("fire_mask", 32'(want.fire_mask), 32'(i_fire_mask));
                    if (i_status !== want.status)
                        note_error("status", 32'(want.status), 32'(i_status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == ptd_tb_pkg::CFG_TICK_MS)
                    tick_len = i_cfg_data[15:0];
                else if (i_cfg_index == ptd_tb_pkg::CFG_PERIOD_BASE)
                    base_len = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                dispatch_op(ptd_tb_pkg::t_op'(i_func), i_task_id, i_period, fresh);
                expected_replies.push_back(fresh);
                n_outstanding++;
            end
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus, handshake pacing and verdict for the periodic task dispatcher.
module tb;

    localparam int TASK_SLOTS     = 8;
    // Quiet cycles allowed before the watchdog ends the run, more than a full tick scan of eight slots takes.
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int PHASE_ITEMS    = 270;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_func = ptd_tb_pkg::OP_TICK;
    logic [7:0]  i_task_id = '0;
    logic [31:0] i_period = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_fire_mask;
    logic [3:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = ptd_tb_pkg::CFG_TICK_MS;
    logic [31:0] i_cfg_data = '0;

    int unsigned replies_seen;
    int unsigned fail_count;
    int unsigned n_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    logic [15:0] cur_tick = 16'd1;
    logic [31:0] cur_base = 32'd60000;

    always #6 i_clk = ~i_clk;

    periodic_task_dispatcher_top #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_task_id   (i_task_id),
        .i_period    (i_period),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fire_mask (o_fire_mask),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ptd_checker #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_period       (i_period),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_fire_mask    (o_fire_mask),
        .i_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_replies_seen (replies_seen),
        .o_fail_count   (fail_count)
    );

    // Stall the reply channel at the rate of the current idling phase.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // End the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("periodic_task_dispatcher_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, optionally after idle cycles, and hold it until the transfer.
    // Valid stays high on return so that back-to-back items need no extra edge.
    task automatic send_item(input ptd_tb_pkg::t_op op, input logic [7:0] id,
                             input logic [31:0] per);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_task_id  <= id;
        i_period   <= per;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_sent++;
    endtask

    // Drop valid and hold off until every reply in flight has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (replies_seen < n_sent);
    endtask

    // Write both registers while the block is idle.
    task automatic set_config(input logic [15:0] tk, input logic [31:0] base);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ptd_tb_pkg::CFG_TICK_MS;
        i_cfg_data  <= {16'd0, tk};
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_index <= ptd_tb_pkg::CFG_PERIOD_BASE;
        i_cfg_data  <= base;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_tick = tk;
        cur_base = base;
    endtask

    // Pick a period that the current setting accepts, mostly a small multiple of the tick
    // so that slots fire often.
    function automatic logic [31:0] fitting_period();
        logic [31:0] p;
        int          k;
        for (k = 0; k < 24; k++) begin
            if ($urandom_range(1))
                p = 32'(cur_tick) * 32'($urandom_range(1, 12));
            else
                p = cur_base / 32'($urandom_range(1, 16));
            if (p != 0 && p >= 32'(cur_tick) && (cur_base % p) == 0)
                return p;
        end
        return cur_base;
    endfunction

    task automatic run_phase(input logic [15:0] tk, input logic [31:0] base, input int count);
        int              n;
        int unsigned     r;
        ptd_tb_pkg::t_op op;
        logic [7:0]      id;
        logic [31:0]     per;
        set_config(tk, base);
        for (n = 0; n < count; n++) begin
            // Rotate idling every 90 items so gaps land on every stage of the work.
            case ((n_sent / 90) % 5)
                1:       begin send_gap_pct = 70; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 70; end
                3:       begin send_gap_pct = 38; stall_pct = 38; end
                default: begin send_gap_pct = 0;  stall_pct = 0;  end
            endcase
            if (n == count / 2)
                drain();

            r = $urandom_range(99);
            if (r < 36)      op = ptd_tb_pkg::OP_TICK;
            else if (r < 48) op = ptd_tb_pkg::OP_REGISTER;
            else if (r < 60) op = ptd_tb_pkg::OP_STOP;
            else if (r < 72) op = ptd_tb_pkg::OP_START;
            else if (r < 94) op = ptd_tb_pkg::OP_SET_PERIOD;
            else             op = ptd_tb_pkg::t_op'($urandom_range(ptd_tb_pkg::OP_RSVD7,
                                                                   ptd_tb_pkg::OP_RSVD5));

            r = $urandom_range(99);
            if (r < 75)      id = 8'($urandom_range(1, TASK_SLOTS));
            else if (r < 85) id = $urandom_range(1) ? 8'd0 : 8'(TASK_SLOTS + 1);
            else             id = 8'($urandom_range(255));

            r = $urandom_range(99);
            if (r < 68)      per = fitting_period();
            else if (r < 76) per = '0;
            else if (r < 84) per = 32'(cur_tick) - 1;
            else if (r < 92) per = fitting_period() * 2;
            else             per = $urandom();

            send_item(op, id, per);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: tick 1 ms, base 60000 ms.
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_STOP, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_START, 8'd9, 32'd0);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd255, 32'd5);
        // Unregistered ids are accepted but must not fire.
        send_item(ptd_tb_pkg::OP_START, 8'd8, 32'd0);
        send_item(ptd_tb_pkg::OP_STOP, 8'd5, 32'd0);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd7);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd255, 32'hFFFF_FFFF);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd1);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd2);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd3);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd4);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd5);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd6);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd60000);
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd8);
        // Table is full now.
        send_item(ptd_tb_pkg::OP_REGISTER, 8'd0, 32'd10);
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_STOP, 8'd1, 32'd0);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd2, 32'd0);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd3, 32'd12);
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_RSVD5, 8'd255, 32'hFFFF_FFFF);
        send_item(ptd_tb_pkg::OP_RSVD7, 8'd1, 32'd1);

        // Period below the tick is rejected even though it divides the base.
        set_config(16'd5, 32'd60000);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd1, 32'd4);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd2, 32'd5);
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);

        // Largest tick: older periods now divide to zero and must stay silent.
        set_config(16'hFFFF, 32'hFFFF_FFFF);
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);
        send_item(ptd_tb_pkg::OP_SET_PERIOD, 8'd4, 32'd65537);
        send_item(ptd_tb_pkg::OP_TICK, 8'd0, 32'd0);

        run_phase(16'd1, 32'd60000, PHASE_ITEMS);
        run_phase(16'd5, 32'd60000, PHASE_ITEMS);
        run_phase(16'd3, 32'd720720, PHASE_ITEMS);
        run_phase(16'hFFFF, 32'hFFFF_FFFF, PHASE_ITEMS);
        run_phase(16'd1, 32'd1, PHASE_ITEMS);
        run_phase(16'd12, 32'd332640, PHASE_ITEMS);
        run_phase(16'd1, 32'd60000, PHASE_ITEMS);

        // Wait out the settle window so that any late or spurious reply is still counted.
        stall_pct = 0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("periodic_task_dispatcher_top: match");
        else
            $display("periodic_task_dispatcher_top: mismatch");
        $finish;
    end

endmodule
